// ===== sv/lied_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lied_pkg: shared constants for the bounded list block
// Sizes of the list store, operation codes and status codes.
// ----------------------------------------------------------------------------
package lied_pkg;

  // list capacity and derived widths
  localparam int DEPTH = 32;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;  // store address
  localparam int CW    = $clog2(DEPTH + 1);                 // entry count

  // field widths
  localparam int VAL_W = 32;
  localparam int POS_W = 16;
  localparam int OP_W  = 2;
  localparam int ST_W  = 2;

  // operation codes (any other code deletes at a position)
  localparam logic [OP_W-1:0] OP_FRONT = 2'd0;
  localparam logic [OP_W-1:0] OP_BACK  = 2'd1;

  // status codes
  localparam logic [ST_W-1:0] ST_DONE  = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd2;

endpackage

// ===== sv/list_insert_ends_delete_at_position.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// list_insert_ends_delete_at_position: bounded ordered list
// Insert at front or back, delete at a position, then stream the whole list.
// ----------------------------------------------------------------------------
// Usage:
//   Each request on the s_ channel is one query: insert item_value at the
//   front, insert it at the back, or delete the entry at position. The list
//   lives in a circular store with a head pointer, so inserts move no entries.
//   A delete closes the gap by moving later entries down one place, each
//   with a read and then a write through the single store port.
//   After each query the m_ channel carries the whole list front to back,
//   one entry per cycle, m_tlast on the final one. An empty list gives one
//   result with list_empty set. Every result of a query carries its status.
//   For a delete within the list, the listing starts only after the later
//   entries have been moved down. The list holds at most 32 entries.
//   s_tready is high only while no query is in progress.
//   Reset empties the list at once; stored values are not cleared.
//   A stall on m_tready holds the current result and pauses the read-out.
// ----------------------------------------------------------------------------
module list_insert_ends_delete_at_position (
  input  logic        clk,
  input  logic        rst,
  // query channel
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // [31:0] item_value, [47:32] position
  input  logic [1:0]  s_tuser,   // [1:0] operation
  // listing channel
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [31:0] entry_value
  output logic [2:0]  m_tuser,   // [0] list_empty, [2:1] status
  output logic        m_tlast
);

  localparam int AW = lied_pkg::AW;
  localparam int CW = lied_pkg::CW;

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_UPD  = 3'd1;
  localparam logic [2:0] S_SHRD = 3'd2;
  localparam logic [2:0] S_SHWR = 3'd3;
  localparam logic [2:0] S_LIST = 3'd4;

  logic [2:0]                   state;
  logic [CW-1:0]                count;
  logic [CW-1:0]                count_next;
  logic [CW-1:0]                idx;
  logic [AW-1:0]                head;
  logic [lied_pkg::OP_W-1:0]    op;
  logic [lied_pkg::VAL_W-1:0]   val;
  logic [lied_pkg::POS_W-1:0]   pos;
  logic [lied_pkg::ST_W-1:0]    status;
  logic [lied_pkg::ST_W-1:0]    status_next;
  logic                         o_valid;
  logic                         o_last;
  logic                         o_empty;
  logic [lied_pkg::VAL_W-1:0]   o_data;
  logic                         rd_valid;
  logic                         rd_last;

  logic                         is_ins;
  logic                         full;
  logic                         in_range;
  logic                         consume;
  logic                         issue;
  logic [AW-1:0]                offset;
  logic [AW-1:0]                phys;
  logic                         ram_we;
  logic                         ram_re;
  logic [lied_pkg::VAL_W-1:0]   ram_wdata;
  logic [lied_pkg::VAL_W-1:0]   ram_rdata;

  // query decode
  always_comb begin
    is_ins   = (op == lied_pkg::OP_FRONT) || (op == lied_pkg::OP_BACK);
    full     = (count == CW'(lied_pkg::DEPTH));
    in_range = (pos < lied_pkg::POS_W'(count));
  end

  // count and status after the update
  always_comb begin
    count_next  = count;
    status_next = lied_pkg::ST_DONE;
    if (is_ins) begin
      if (full) begin
        status_next = lied_pkg::ST_FULL;
      end else begin
        count_next = count + CW'(1);
      end
    end else begin
      if (!in_range) begin
        status_next = lied_pkg::ST_RANGE;
      end else begin
        count_next = count - CW'(1);
      end
    end
  end

  // read-out pipeline: store read -> output register
  always_comb begin
    consume = rd_valid && (!o_valid || m_tready);
    issue   = (state == S_LIST) && (idx < count) && (!rd_valid || consume);
  end

  // logical offset fed to the shared address unit
  always_comb begin
    case (state)
      S_UPD: begin
        if (op == lied_pkg::OP_FRONT) begin
          offset = AW'(lied_pkg::DEPTH - 1);
        end else begin
          offset = count[AW-1:0];
        end
      end
      S_SHRD:  offset = idx[AW-1:0] + AW'(1);
      default: offset = idx[AW-1:0];
    endcase
  end

  lied_addr u_addr (
    .base   (head),
    .offset (offset),
    .phys   (phys)
  );

  // store controls
  always_comb begin
    ram_we    = ((state == S_UPD) && is_ins && !full) || (state == S_SHWR);
    ram_re    = (state == S_SHRD) || issue;
    ram_wdata = (state == S_SHWR) ? ram_rdata : val;
  end

  lied_ram #(
    .DEPTH (lied_pkg::DEPTH),
    .WIDTH (lied_pkg::VAL_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .re    (ram_re),
    .addr  (phys),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      head     <= '0;
      o_valid  <= 1'b0;
      rd_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            op    <= s_tuser;
            val   <= s_tdata[31:0];
            pos   <= s_tdata[47:32];
            state <= S_UPD;
          end
        end
        S_UPD: begin
          count    <= count_next;
          status   <= status_next;
          idx      <= '0;
          rd_valid <= 1'b0;
          // empty list: single result straight away
          o_valid  <= (count_next == '0);
          o_empty  <= (count_next == '0);
          o_last   <= 1'b1;
          o_data   <= '0;
          if (is_ins && !full && (op == lied_pkg::OP_FRONT)) begin
            head <= phys;
          end
          if (!is_ins && in_range && (pos < lied_pkg::POS_W'(count_next))) begin
            idx   <= pos[CW-1:0];
            state <= S_SHRD;
          end else begin
            state <= S_LIST;
          end
        end
        S_SHRD: begin
          state <= S_SHWR;
        end
        S_SHWR: begin
          // entry idx+1 now sits at idx
          if (idx + CW'(1) == count) begin
            idx   <= '0;
            state <= S_LIST;
          end else begin
            idx   <= idx + CW'(1);
            state <= S_SHRD;
          end
        end
        S_LIST: begin
          if (issue) begin
            idx      <= idx + CW'(1);
            rd_last  <= (idx + CW'(1) == count);
            rd_valid <= 1'b1;
          end else if (consume) begin
            rd_valid <= 1'b0;
          end
          if (consume) begin
            o_valid <= 1'b1;
            o_data  <= ram_rdata;
            o_last  <= rd_last;
          end else if (m_tready) begin
            o_valid <= 1'b0;
          end
          if (o_valid && m_tready && o_last) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // ports
  assign s_tready = (state == S_IDLE);
  assign m_tvalid = o_valid;
  assign m_tdata  = o_data;
  assign m_tuser  = {status, o_empty};
  assign m_tlast  = o_last;

endmodule

// ===== sv/lied_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lied_ram: single-port list store
// One write or one read per cycle; read data is registered and holds
// until the next read.
// ----------------------------------------------------------------------------
module lied_ram #(
  parameter int DEPTH = 32,
  parameter int WIDTH = 32,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic             re,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

// ===== sv/lied_addr.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lied_addr: circular address unit
// Maps a logical list offset onto a store address: (base + offset) mod DEPTH.
// ----------------------------------------------------------------------------
module lied_addr (
  input  logic [lied_pkg::AW-1:0] base,
  input  logic [lied_pkg::AW-1:0] offset,
  output logic [lied_pkg::AW-1:0] phys
);

  logic [lied_pkg::AW:0] sum;

  // one add, one compare-and-subtract wrap
  always_comb begin
    sum = {1'b0, base} + {1'b0, offset};
    if (sum >= (lied_pkg::AW + 1)'(lied_pkg::DEPTH)) begin
      sum = sum - (lied_pkg::AW + 1)'(lied_pkg::DEPTH);
    end
    phys = sum[lied_pkg::AW-1:0];
  end

endmodule

// ===== sv/lied_chk.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lied_chk: port-level checks for the bounded list block
// Watches both channels and the query/listing alternation.
// ----------------------------------------------------------------------------
module lied_chk (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic [2:0]  m_tuser,
  input logic        m_tlast
);

  // no new query while a listing is on the bus
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && m_tvalid))
    else $error("query taken while listing in progress");

  // a taken query closes the input side
  a_busy_after_req: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input still ready after a query request");

  // empty marker only on a single, final result
  a_empty_is_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[0]) |-> m_tlast)
    else $error("empty result not marked last");

  // end of listing reopens the input side
  a_ready_after_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && m_tlast) |=> s_tready)
    else $error("input not ready after final result");

  // stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=>
      (m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast)))
    else $error("result changed under stall");

endmodule

bind list_insert_ends_delete_at_position lied_chk u_lied_chk (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);
